// ===== hw/rtl/tdi_pkg.sv =====
// Package for the timestamped delay interpolator.
// Holds the widths, reset constants, the sequencer state type and the divider result type.
// It has no dependencies. All other files in hw/rtl use it.
package tdi_pkg;

   localparam int RING_DEPTH = 64;
   localparam int TIME_W     = 48;
   localparam int DELTA_W    = 20;
   localparam int LAG_W      = 24;
   localparam int POS_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int WORD_W     = TIME_W + 3 * POS_W;

   localparam logic [LAG_W-1:0]  LAG_RESET = LAG_W'(500000);
   localparam logic [FRAC_W:0]   ONE_Q16   = {1'b1, {FRAC_W{1'b0}}};

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_RD_A,
      ST_LD_A,
      ST_LD_B,
      ST_FRAC,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   // Result that the divider returns to the sequencer.
   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_result_type;

endpackage

// ===== hw/rtl/tdi_req_if.sv =====
// Request channel of the delay interpolator: time step and leader position.
// Depends on tdi_pkg for the field widths.
interface tdi_req_if;
   logic                               valid;
   logic                               ready;
   logic        [tdi_pkg::DELTA_W-1:0] delta_time;
   logic signed [tdi_pkg::POS_W-1:0]   leader_x;
   logic signed [tdi_pkg::POS_W-1:0]   leader_y;
   logic signed [tdi_pkg::POS_W-1:0]   leader_z;

   modport source (output valid, delta_time, leader_x, leader_y, leader_z, input ready);
   modport sink (input valid, delta_time, leader_x, leader_y, leader_z, output ready);
endinterface

// ===== hw/rtl/tdi_rsp_if.sv =====
// Response channel of the delay interpolator: the delayed trail position.
// Depends on tdi_pkg for the field widths.
interface tdi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [tdi_pkg::POS_W-1:0] trail_x;
   logic signed [tdi_pkg::POS_W-1:0] trail_y;
   logic signed [tdi_pkg::POS_W-1:0] trail_z;

   modport source (output valid, trail_x, trail_y, trail_z, input ready);
   modport sink (input valid, trail_x, trail_y, trail_z, output ready);
endinterface

// ===== hw/rtl/tdi_csr_if.sv =====
// Configuration write channel of the delay interpolator: the lag time register.
// Depends on tdi_pkg for the register width.
interface tdi_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tdi_pkg::LAG_W-1:0]   lag_time;

   modport source (output valid, lag_time, input ready);
   modport sink (input valid, lag_time, output ready);
endinterface

// ===== hw/rtl/timestamped_delay_interpolator_unit.sv =====
// Timestamped delay interpolator: returns where a leader was lag_time ticks ago.
// Depends on tdi_pkg, the three channel interfaces, tdi_ring and tdi_divider.
//
// Each request carries delta_time and the leader position. The block adds the
// step to a 48-bit timer, stores the stamped position in a ring, walks the
// oldest pointer up to the target time and interpolates between the oldest
// slot and its successor. Exactly one response follows each request.
// The csr channel writes lag_time; it is always ready. The user must write it
// only while idle; the block itself does not enforce this. Steps: take the
// request, write the ring, a read and a compare for each walk step, the final
// compare included, fetch the bracketing slots, set up, divide for the fraction
// when needed, a multiply and an add for each of the three blends, and hand off.
// A new request is taken only once the previous one has reached the response
// register.
// A stalled receiver holds the response; the block may finish the next request
// meanwhile and then waits in its last step until the response register frees.
// Reset clears the timer, the oldest pointer and the ring fill count at once and
// sets the newest pointer to slot 1, so the ring reads as all zero without a clearing pass; lag_time returns to 500000.
module timestamped_delay_interpolator_unit #(
   parameter int RING_DEPTH = tdi_pkg::RING_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   tdi_req_if.sink    req_if,
   tdi_rsp_if.source  rsp_if,
   tdi_csr_if.sink    csr_if
);
   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int STEP_W = $clog2(RING_DEPTH + 1);
   localparam int TW     = tdi_pkg::TIME_W;
   localparam int PW     = tdi_pkg::POS_W;
   localparam int FW     = tdi_pkg::FRAC_W;
   localparam int PROD_W = PW + 1 + FW + 2;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RING_DEPTH - 1);

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s);
      logic [ADDR_W-1:0] n;
      if (s == LAST_SLOT) begin
         n = '0;
      end else begin
         n = s + ADDR_W'(1);
      end
      return n;
   endfunction

   tdi_pkg::state_type state_ff, state_in;

   logic [TW-1:0]              timer_ff;
   logic [TW-1:0]              target_ff;
   logic                       early_ff;
   logic [tdi_pkg::LAG_W-1:0]  lag_ff;
   logic [ADDR_W-1:0]          newest_ff;
   logic [ADDR_W-1:0]          oldest_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [3*PW-1:0]            pos_ff;
   logic [tdi_pkg::WORD_W-1:0] a_ff, b_ff;
   logic [FW:0]                frac_ff;
   logic [1:0]                 coord_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [3*PW-1:0]            res_ff;
   logic [3*PW-1:0]            out_ff;
   logic                       rsp_valid_ff;

   logic                       req_take;
   logic                       ring_we;
   logic [ADDR_W-1:0]          ring_rd_addr;
   logic [tdi_pkg::WORD_W-1:0] ring_rd_data;
   logic                       div_start;
   tdi_pkg::div_result_type    div_res;
   logic                       out_free;

   logic [TW-1:0]              t_new;
   logic [ADDR_W-1:0]          cand;
   logic [TW-1:0]              rd_stamp;
   logic                       walk_go;
   logic [TW-1:0]              a_stamp, b_stamp;
   logic [TW-1:0]              num, span;
   logic                       frac_live;
   logic signed [PW-1:0]       a_pos, b_pos;
   logic signed [PW:0]         diff;
   logic signed [FW+1:0]       frac_s;
   logic [PW-1:0]              blend;

   // Ring memory of stamp and position words.
   tdi_ring #(.DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_we),
      .wr_addr (newest_ff),
      .wr_data ({timer_ff, pos_ff}),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // Fraction divider.
   tdi_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num),
      .den    (span),
      .result (div_res)
   );

   // Datapath helpers.
   always_comb begin
      t_new     = timer_ff + TW'(req_if.delta_time);
      cand      = next_slot(newest_ff);
      rd_stamp  = ring_rd_data[tdi_pkg::WORD_W-1 -: TW];
      walk_go   = rd_stamp < target_ff;
      a_stamp   = a_ff[tdi_pkg::WORD_W-1 -: TW];
      b_stamp   = b_ff[tdi_pkg::WORD_W-1 -: TW];
      num       = target_ff - a_stamp;
      span      = b_stamp - a_stamp;
      frac_live = (b_stamp > a_stamp) && !early_ff && (target_ff > a_stamp);
      out_free  = !rsp_valid_ff || rsp_if.ready;
      case (coord_ff)
         2'd0: begin
            a_pos = a_ff[3*PW-1 -: PW];
            b_pos = b_ff[3*PW-1 -: PW];
         end
         2'd1: begin
            a_pos = a_ff[2*PW-1 -: PW];
            b_pos = b_ff[2*PW-1 -: PW];
         end
         default: begin
            a_pos = a_ff[PW-1:0];
            b_pos = b_ff[PW-1:0];
         end
      endcase
      diff   = {b_pos[PW-1], b_pos} - {a_pos[PW-1], a_pos};
      frac_s = {1'b0, frac_ff};
      blend  = a_pos + prod_ff[FW +: PW];
   end

   // Sequencer control outputs.
   always_comb begin
      req_take     = 1'b0;
      ring_we      = 1'b0;
      div_start    = 1'b0;
      ring_rd_addr = next_slot(oldest_ff);
      case (state_ff)
         tdi_pkg::ST_IDLE:  req_take = req_if.valid;
         tdi_pkg::ST_WRITE: ring_we = 1'b1;
         tdi_pkg::ST_RD_A:  ring_rd_addr = oldest_ff;
         tdi_pkg::ST_FRAC:  div_start = frac_live && (num < span);
         default:           ring_rd_addr = next_slot(oldest_ff);
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdi_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = tdi_pkg::ST_WRITE;
            end
         end
         tdi_pkg::ST_WRITE: begin
            state_in = early_ff ? tdi_pkg::ST_RD_A : tdi_pkg::ST_WALK_RD;
         end
         tdi_pkg::ST_WALK_RD: state_in = tdi_pkg::ST_WALK_CMP;
         tdi_pkg::ST_WALK_CMP: begin
            if (walk_go && step_ff != STEP_W'(RING_DEPTH - 1)) begin
               state_in = tdi_pkg::ST_WALK_RD;
            end else begin
               state_in = tdi_pkg::ST_RD_A;
            end
         end
         tdi_pkg::ST_RD_A: state_in = tdi_pkg::ST_LD_A;
         tdi_pkg::ST_LD_A: state_in = tdi_pkg::ST_LD_B;
         tdi_pkg::ST_LD_B: state_in = tdi_pkg::ST_FRAC;
         tdi_pkg::ST_FRAC: begin
            state_in = (frac_live && num < span) ? tdi_pkg::ST_DIV : tdi_pkg::ST_MUL;
         end
         tdi_pkg::ST_DIV: begin
            if (div_res.done) begin
               state_in = tdi_pkg::ST_MUL;
            end
         end
         tdi_pkg::ST_MUL: state_in = tdi_pkg::ST_ADD;
         tdi_pkg::ST_ADD: begin
            state_in = (coord_ff == 2'd2) ? tdi_pkg::ST_DONE : tdi_pkg::ST_MUL;
         end
         tdi_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tdi_pkg::ST_IDLE;
            end
         end
         default: state_in = tdi_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdi_pkg::ST_IDLE;
         timer_ff     <= '0;
         lag_ff       <= tdi_pkg::LAG_RESET;
         newest_ff    <= ADDR_W'(1);
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) begin
            lag_ff <= csr_if.lag_time;
         end
         if (req_take) begin
            timer_ff <= t_new;
            if (cand != oldest_ff) begin
               newest_ff <= cand;
            end
         end
         if (state_ff == tdi_pkg::ST_WALK_CMP && walk_go) begin
            oldest_ff <= next_slot(oldest_ff);
         end
         if (state_ff == tdi_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         pos_ff    <= {req_if.leader_x, req_if.leader_y, req_if.leader_z};
         early_ff  <= t_new < TW'(lag_ff);
         target_ff <= t_new - TW'(lag_ff);
      end
      if (state_ff == tdi_pkg::ST_WRITE) begin
         step_ff <= '0;
      end else if (state_ff == tdi_pkg::ST_WALK_CMP) begin
         step_ff <= step_ff + STEP_W'(1);
      end
      if (state_ff == tdi_pkg::ST_LD_A) begin
         a_ff <= ring_rd_data;
      end
      if (state_ff == tdi_pkg::ST_LD_B) begin
         b_ff <= ring_rd_data;
      end
      if (state_ff == tdi_pkg::ST_FRAC) begin
         frac_ff  <= frac_live ? tdi_pkg::ONE_Q16 : '0;
         coord_ff <= 2'd0;
      end
      if (state_ff == tdi_pkg::ST_DIV && div_res.done) begin
         frac_ff <= {1'b0, div_res.quot};
      end
      if (state_ff == tdi_pkg::ST_MUL) begin
         prod_ff <= diff * frac_s;
      end
      if (state_ff == tdi_pkg::ST_ADD) begin
         case (coord_ff)
            2'd0:    res_ff[3*PW-1 -: PW] <= blend;
            2'd1:    res_ff[2*PW-1 -: PW] <= blend;
            default: res_ff[PW-1:0] <= blend;
         endcase
         coord_ff <= coord_ff + 2'd1;
      end
      if (state_ff == tdi_pkg::ST_DONE && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign req_if.ready   = req_take;
   assign csr_if.ready   = 1'b1;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.trail_x = out_ff[3*PW-1 -: PW];
   assign rsp_if.trail_y = out_ff[2*PW-1 -: PW];
   assign rsp_if.trail_z = out_ff[PW-1:0];
endmodule

// ===== hw/rtl/tdi_ring.sv =====
// Ring memory of stamped positions with one write port and one registered read port.
// Depends on tdi_pkg. A fill count marks the slots written since reset; others read as zero.
module tdi_ring #(
   parameter int DEPTH = tdi_pkg::RING_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [tdi_pkg::WORD_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [tdi_pkg::WORD_W-1:0]       rd_data
);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   // Position of a slot in the order in which slots are first written.
   function automatic logic [ADDR_W-1:0] slot_order(input logic [ADDR_W-1:0] s);
      logic [ADDR_W-1:0] o;
      if (s >= ADDR_W'(2)) begin
         o = s - ADDR_W'(2);
      end else begin
         o = s + ADDR_W'(DEPTH - 2);
      end
      return o;
   endfunction

   logic [tdi_pkg::WORD_W-1:0] mem [DEPTH];
   logic [tdi_pkg::WORD_W-1:0] rd_word_ff;
   logic                       rd_written_ff;
   logic                       rd_written_in;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic [ADDR_W-1:0]          rd_order;
   logic [ADDR_W-1:0]          wr_order;

   // Slots are first written in the order 2, 3, ..., DEPTH-1, 0, 1. Rewriting the
   // newest slot while the ring is full does not add to the fill count.
   always_comb begin
      rd_order = slot_order(rd_addr);
      wr_order = slot_order(wr_addr);
      rd_written_in = FILL_W'(rd_order) < fill_ff;
      fill_in = fill_ff;
      if (wr_en && fill_ff != FILL_W'(DEPTH) && FILL_W'(wr_order) == fill_ff) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Memory array with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff    <= mem[rd_addr];
      rd_written_ff <= rd_written_in;
   end

   assign rd_data = rd_written_ff ? rd_word_ff : '0;
endmodule

// ===== hw/rtl/tdi_divider.sv =====
// Restoring divider giving a 16-bit fraction num * 65536 / den for num below den.
// Depends on tdi_pkg. One quotient bit per cycle from a single compare and subtract.
module tdi_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tdi_pkg::TIME_W-1:0]    num,
   input  logic [tdi_pkg::TIME_W-1:0]    den,
   output tdi_pkg::div_result_type       result
);
   localparam int CNT_W = $clog2(tdi_pkg::FRAC_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [tdi_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [tdi_pkg::TIME_W-1:0]    den_ff, den_in;
   logic [tdi_pkg::FRAC_W-1:0]    quot_ff, quot_in;
   logic [tdi_pkg::TIME_W:0]      shifted;
   logic [tdi_pkg::TIME_W:0]      diff;

   // One shift, compare and subtract step.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = diff[tdi_pkg::TIME_W-1:0];
            quot_in = {quot_ff[tdi_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[tdi_pkg::TIME_W-1:0];
            quot_in = {quot_ff[tdi_pkg::FRAC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(tdi_pkg::FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
endmodule

// ===== dv/timestamped_delay_interpolator_unit_tb.sv =====
// Testbench for the timestamped delay interpolator unit.
// Depends on tdi_pkg, the three channel interfaces and the unit itself; a local
// model of the ring, the timer and the interpolation predicts every response.
module timestamped_delay_interpolator_unit_tb;

   localparam int DEPTH = tdi_pkg::RING_DEPTH;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [tdi_pkg::POS_W-1:0] x;
      logic [tdi_pkg::POS_W-1:0] y;
      logic [tdi_pkg::POS_W-1:0] z;
   } point_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   fail_count;
   int   max_gap;

   tdi_req_if req_if ();
   tdi_rsp_if rsp_if ();
   tdi_csr_if csr_if ();

   timestamped_delay_interpolator_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   // Model state of the ring and the timer.
   point_type                   trail_ring [DEPTH];
   logic [tdi_pkg::TIME_W-1:0]  stamp_ring [DEPTH];
   logic [tdi_pkg::TIME_W-1:0]  timer;
   int                          oldest;
   int                          newest;
   logic [tdi_pkg::LAG_W-1:0]   lag;
   point_type                   pending_trail [$];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void clear_model();
      for (int i = 0; i < DEPTH; i++) begin
         trail_ring[i] = '0;
         stamp_ring[i] = '0;
      end
      timer = '0;
      oldest = 0;
      newest = 1 % DEPTH;
      lag = tdi_pkg::LAG_RESET;
   endfunction

   // Linear blend a + floor((b - a) * frac / 65536).
   function automatic logic [tdi_pkg::POS_W-1:0] blend_coord(
         logic [tdi_pkg::POS_W-1:0] a,
         logic [tdi_pkg::POS_W-1:0] b,
         logic [tdi_pkg::FRAC_W:0]  frac);
      longint sa;
      longint diff;
      longint prod;
      sa = longint'($signed(a));
      diff = longint'($signed(b)) - sa;
      prod = diff * longint'(frac);
      return tdi_pkg::POS_W'(sa + (prod >>> 16));
   endfunction

   // Advance the model by one request and queue the expected trail position.
   function automatic void predict_trail(logic [tdi_pkg::DELTA_W-1:0] dt, point_type lead);
      int                         cand;
      int                         nxt;
      logic                       early;
      logic [tdi_pkg::TIME_W-1:0] target;
      logic [tdi_pkg::TIME_W-1:0] base;
      logic [tdi_pkg::TIME_W-1:0] span;
      logic [tdi_pkg::TIME_W-1:0] num;
      logic [tdi_pkg::FRAC_W:0]   frac;
      point_type                  a;
      point_type                  b;
      timer = timer + tdi_pkg::TIME_W'(dt);
      cand = (newest + 1) % DEPTH;
      if (cand != oldest) newest = cand;
      trail_ring[newest] = lead;
      stamp_ring[newest] = timer;
      early = timer < tdi_pkg::TIME_W'(lag);
      target = early ? '0 : timer - tdi_pkg::TIME_W'(lag);
      for (int k = 0; k < DEPTH; k++) begin
         nxt = (oldest + 1) % DEPTH;
         if (!early && stamp_ring[nxt] < target) oldest = nxt;
         else break;
      end
      nxt = (oldest + 1) % DEPTH;
      base = stamp_ring[oldest];
      frac = '0;
      if (stamp_ring[nxt] > base && !early && target > base) begin
         num = target - base;
         span = stamp_ring[nxt] - base;
         if (num >= span) frac = tdi_pkg::ONE_Q16;
         else frac = (tdi_pkg::FRAC_W+1)'(({16'b0, num} << 16) / {16'b0, span});
      end
      a = trail_ring[oldest];
      b = trail_ring[nxt];
      pending_trail.push_back('{blend_coord(a.x, b.x, frac),
                                blend_coord(a.y, b.y, frac),
                                blend_coord(a.z, b.z, frac)});
   endfunction

   // Drop the request valid once no further request follows at once.
   task automatic release_request();
      req_if.valid <= 1'b0;
   endtask

   // Send one request after a random gap and update the prediction on acceptance.
   // The valid stays high after acceptance so that a request with no gap follows directly.
   task automatic send_request(logic [tdi_pkg::DELTA_W-1:0] dt, point_type lead);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.delta_time <= dt;
      req_if.leader_x <= lead.x;
      req_if.leader_y <= lead.y;
      req_if.leader_z <= lead.z;
      do @(posedge clock); while (!req_if.ready);
      predict_trail(dt, lead);
   endtask

   // Write lag_time once the unit is idle.
   task automatic write_lag(logic [tdi_pkg::LAG_W-1:0] value);
      release_request();
      wait (pending_trail.size() == 0);
      repeat (4) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.lag_time <= value;
      do @(posedge clock); while (!csr_if.ready);
      lag = value;
      csr_if.valid <= 1'b0;
   endtask

   function automatic point_type random_point();
      return '{$urandom(), $urandom(), $urandom()};
   endfunction

   // Response ready with random stalls, and the field check.
   initial begin
      point_type want;
      int        stall;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = (max_gap == 0) ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (pending_trail.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_trail.pop_front();
            if (rsp_if.trail_x !== want.x) begin
               $error("trail_x expected %h actual %h", want.x, rsp_if.trail_x);
               fail_count++;
            end
            if (rsp_if.trail_y !== want.y) begin
               $error("trail_y expected %h actual %h", want.y, rsp_if.trail_y);
               fail_count++;
            end
            if (rsp_if.trail_z !== want.z) begin
               $error("trail_z expected %h actual %h", want.z, rsp_if.trail_z);
               fail_count++;
            end
         end
      end
   end

   // Extremes of position and step under the reset lag, including the early target.
   task automatic test_extremes();
      send_request('0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
      send_request(20'hFFFFF, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
      send_request(20'h00001, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
      send_request(20'hAAAAA, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000});
      send_request(20'h55555, '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000});
      for (int i = 0; i < 6; i++) send_request(20'(i * 120000), random_point());
   endtask

   // Zero lag: the target equals the timer, and zero steps give a zero span.
   task automatic test_zero_lag();
      write_lag('0);
      for (int i = 0; i < 5; i++) send_request(i[0] ? 20'h0 : 20'h10, random_point());
   endtask

   // Short lag with many small steps fills the ring and overwrites the newest slot.
   task automatic test_ring_full();
      write_lag(24'd100000);
      for (int i = 0; i < 3 * DEPTH; i++)
         send_request(20'($urandom_range(0, 40)), random_point());
   endtask

   // Random traffic over several lag settings, the largest among them.
   task automatic test_random(int count);
      logic [tdi_pkg::LAG_W-1:0] lags [5];
      lags = '{24'hFFFFFF, 24'd1000, 24'd300000, 24'd2000000, 24'd0};
      for (int p = 0; p < 5; p++) begin
         write_lag(lags[p]);
         for (int i = 0; i < count / 5; i++) begin
            max_gap = ($urandom_range(0, 7) == 0) ? 0 : 14;
            case ($urandom_range(0, 3))
               0: send_request(20'($urandom()), random_point());
               1: send_request(20'($urandom_range(0, 3)), random_point());
               default: send_request(20'($urandom_range(0, 200000)), random_point());
            endcase
         end
      end
      max_gap = 14;
   endtask

   // Stimulus sequence and the final verdict.
   initial begin
      cycle_count = 0;
      fail_count = 0;
      max_gap = 14;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.delta_time = '0;
      req_if.leader_x = '0;
      req_if.leader_y = '0;
      req_if.leader_z = '0;
      csr_if.valid = 1'b0;
      csr_if.lag_time = '0;
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_zero_lag();
      test_ring_full();
      test_random(1250);
      release_request();
      wait (pending_trail.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
